[src/bfha_pkg.sv]
// Shared constants, codes and types of the best-fit heap allocator.
// Used by bfha_cfg and best_fit_heap_allocator; depends on nothing.
package bfha_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam int FREE_SLOTS_DEF = 8192;
	localparam int HEADER_BYTES = 8;
	localparam int MIN_HEAP_BYTES = 4096;
	localparam int SPLIT_SPARE = 32;

	localparam int REQ_W = 17;
	localparam int OFFS_W = 16;
	localparam int STAT_W = 2;
	localparam int FREEC_W = 14;
	localparam int CFG_W = 17;
	localparam int EFF_W = 21;

	localparam logic [CFG_W-1:0] HEAP_BYTES_RST = 17'd65536;

	// chunk header status codes
	localparam logic [1:0] CK_NONE = 2'd0;
	localparam logic [1:0] CK_ALLOC = 2'd1;
	localparam logic [1:0] CK_FREE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] RES_OK = 2'd0;
	localparam logic [STAT_W-1:0] RES_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] RES_BADREL = 2'd2;

	// register index of heap_bytes
	localparam logic REG_HEAP = 1'b0;

	typedef struct packed {
		logic wr;
		logic [EFF_W-1:0] heap_eff;
	} cfg_t;

endpackage

[src/bfha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the free list and the chunk table; no dependencies.
module bfha_ram #(
	parameter int W = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/bfha_cfg.sv]
// APB register slice holding heap_bytes and its effective (clamped) heap size.
// Depends on bfha_pkg.
module bfha_cfg #(
	parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output bfha_pkg::cfg_t    cfg
);

	logic [bfha_pkg::CFG_W-1:0] heap_bytes_q;
	logic                       wr;
	logic [bfha_pkg::CFG_W:0]   rnd;
	logic [bfha_pkg::EFF_W-1:0] eff;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite & (paddr[2] == bfha_pkg::REG_HEAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q <= bfha_pkg::HEAP_BYTES_RST;
		end else if (wr) begin
			heap_bytes_q <= pwdata[bfha_pkg::CFG_W-1:0];
		end
	end

	// round up to four bytes, then clamp to the legal range
	always_comb begin
		rnd = ({1'b0, heap_bytes_q} + 18'd3) & ~18'd3;
		if (bfha_pkg::EFF_W'(rnd) < bfha_pkg::EFF_W'(bfha_pkg::MIN_HEAP_BYTES)) begin
			eff = bfha_pkg::EFF_W'(bfha_pkg::MIN_HEAP_BYTES);
		end else if (bfha_pkg::EFF_W'(rnd) > bfha_pkg::EFF_W'(HEAP_BYTES)) begin
			eff = bfha_pkg::EFF_W'(HEAP_BYTES);
		end else begin
			eff = bfha_pkg::EFF_W'(rnd);
		end
	end

	assign cfg.wr = wr;
	assign cfg.heap_eff = eff;
	assign prdata = (paddr[2] == bfha_pkg::REG_HEAP) ? 32'(heap_bytes_q) : 32'd0;

endmodule

[src/best_fit_heap_allocator.sv]
// Best-fit heap allocator: free-list walk, chunk table and result register.
// Allocate walks the whole free list for the smallest fitting chunk, then may shift list entries.
// Release walks the free chunks below the offset, merges neighbours and may shift list entries.
// Words are taken one at a time, only while idle; the free-list RAM port sets the walk and shift pace.
// Reset and each heap_bytes write run a clearing pass over the chunk table (no input).
// Depends on bfha_pkg, bfha_ram and bfha_cfg.
module best_fit_heap_allocator #(
	parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF,
	parameter int FREE_SLOTS = bfha_pkg::FREE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // request_size[16:0], release_offset[32:17], zero pad
	input  logic        s_tuser,  // operation[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // granted_offset[15:0], result_status[17:16], free_chunks[31:18]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SZ_W = $clog2(HEAP_BYTES + 1);
	localparam int OFF_W = $clog2(HEAP_BYTES);
	localparam int CI_W = OFF_W - 2;
	localparam int CHUNK_SLOTS = HEAP_BYTES / 4;
	localparam int FL_AW = $clog2(FREE_SLOTS);
	localparam int CNT_W = $clog2(FREE_SLOTS + 1);
	localparam int CW_W = SZ_W + 2;
	localparam int AW = ((SZ_W > 19) ? SZ_W : 19) + 1;
	localparam int NEED_W = bfha_pkg::REQ_W + 1;

	localparam logic [AW-1:0] HDR_X = AW'(bfha_pkg::HEADER_BYTES);
	localparam logic [AW-1:0] SPARE_X = AW'(bfha_pkg::SPLIT_SPARE);

	// sequencer states
	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_INIT   = 5'd1;
	localparam logic [4:0] S_IDLE   = 5'd2;
	localparam logic [4:0] S_A_RDL  = 5'd3;
	localparam logic [4:0] S_A_RDC  = 5'd4;
	localparam logic [4:0] S_A_CMP  = 5'd5;
	localparam logic [4:0] S_A_DEC  = 5'd6;
	localparam logic [4:0] S_R_CHK  = 5'd7;
	localparam logic [4:0] S_R_RDL  = 5'd8;
	localparam logic [4:0] S_R_LCMP = 5'd9;
	localparam logic [4:0] S_R_NRD  = 5'd10;
	localparam logic [4:0] S_R_NGET = 5'd11;
	localparam logic [4:0] S_R_PGET = 5'd12;
	localparam logic [4:0] S_R_DEC  = 5'd13;
	localparam logic [4:0] S_CW     = 5'd14;
	localparam logic [4:0] S_SD_RD  = 5'd15;
	localparam logic [4:0] S_SD_WR  = 5'd16;
	localparam logic [4:0] S_SU_RD  = 5'd17;
	localparam logic [4:0] S_SU_WR  = 5'd18;
	localparam logic [4:0] S_FIN    = 5'd19;

	// follow-up after the queued chunk-table writes
	localparam logic [1:0] POST_NONE = 2'd0;
	localparam logic [1:0] POST_DOWN = 2'd1;
	localparam logic [1:0] POST_UP   = 2'd2;

	bfha_pkg::cfg_t cfg;

	bfha_cfg #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [AW-1:0] heap_eff;
	assign heap_eff = AW'(cfg.heap_eff);

	// free list RAM: header offsets in ascending order
	logic             fl_we;
	logic [FL_AW-1:0] fl_waddr;
	logic [OFF_W-1:0] fl_wdata;
	logic [FL_AW-1:0] fl_raddr;
	logic [OFF_W-1:0] fl_rdata;

	bfha_ram #(
		.W     (OFF_W),
		.DEPTH (FREE_SLOTS)
	) u_free_list (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (fl_raddr),
		.rdata (fl_rdata)
	);

	// chunk table RAM: {status, size} per 4-byte word
	logic            ck_we;
	logic [CI_W-1:0] ck_waddr;
	logic [CW_W-1:0] ck_wdata;
	logic [CI_W-1:0] ck_raddr;
	logic [CW_W-1:0] ck_rdata;

	bfha_ram #(
		.W     (CW_W),
		.DEPTH (CHUNK_SLOTS)
	) u_chunks (
		.clk   (clk),
		.we    (ck_we),
		.waddr (ck_waddr),
		.wdata (ck_wdata),
		.raddr (ck_raddr),
		.rdata (ck_rdata)
	);

	logic [4:0]        state_q;
	logic [CI_W-1:0]   clr_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  a_q;
	logic [NEED_W-1:0] need_q;
	logic [OFF_W-1:0]  p_q;
	logic [SZ_W-1:0]   psize_q;
	logic [OFF_W-1:0]  hdr_q;
	logic [OFF_W-1:0]  n_q;
	logic [OFF_W-1:0]  prev_q;
	logic [SZ_W-1:0]   nsize_q;
	logic [SZ_W-1:0]   prevsize_q;
	logic              found_q;
	logic [CNT_W-1:0]  best_i_q;
	logic [OFF_W-1:0]  best_hdr_q;
	logic [SZ_W-1:0]   best_size_q;
	logic [1:0]        res_status_q;
	logic [15:0]       res_grant_q;
	logic [CI_W-1:0]   wq_addr_q [3];
	logic [CW_W-1:0]   wq_data_q [3];
	logic [1:0]        wq_n_q;
	logic [1:0]        wq_k_q;
	logic [1:0]        post_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	// input word fields
	logic                       in_op;
	logic [bfha_pkg::REQ_W-1:0] in_req;
	logic [bfha_pkg::OFFS_W-1:0] in_off;
	assign in_op = s_tuser;
	assign in_req = s_tdata[16:0];
	assign in_off = s_tdata[32:17];

	logic          accept;
	logic [AW-1:0] off_x;
	logic [AW-1:0] p_x;
	logic          rel_bad;
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid & s_tready;
	assign off_x = AW'(in_off);
	assign p_x = off_x - HDR_X;
	assign rel_bad = (off_x < HDR_X) || (off_x[1:0] != 2'd0) || (p_x >= heap_eff);

	// allocate datapath
	logic [AW-1:0] need8_x;
	logic [AW-1:0] cur_size_x;
	logic          fits;
	logic          better;
	logic          split;
	logic [AW-1:0] tail_x;
	assign need8_x = AW'(need_q) + HDR_X;
	assign cur_size_x = AW'(ck_rdata[SZ_W-1:0]);
	assign fits = (cur_size_x >= need8_x);
	assign better = !found_q || (cur_size_x < AW'(best_size_q));
	assign split = (AW'(best_size_q) >= need8_x + SPARE_X);
	assign tail_x = AW'(best_hdr_q) + need8_x;

	// release datapath
	logic          has_next;
	logic          mrg_next;
	logic          mrg_prev;
	logic          list_full;
	assign has_next = (i_q != count_q);
	assign mrg_next = has_next && (AW'(n_q) == AW'(p_q) + AW'(psize_q));
	assign mrg_prev = (i_q != '0) && (AW'(prev_q) + AW'(prevsize_q) == AW'(p_q));
	assign list_full = (count_q >= CNT_W'(FREE_SLOTS));

	// load the result register only when it is free or being drained this cycle
	logic out_load;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || m_tready) && !cfg.wr;

	// RAM port steering
	always_comb begin
		fl_we = 1'b0;
		fl_waddr = i_q[FL_AW-1:0];
		fl_wdata = p_q;
		fl_raddr = i_q[FL_AW-1:0];
		ck_we = 1'b0;
		ck_waddr = clr_idx_q;
		ck_wdata = '0;
		ck_raddr = p_x[OFF_W-1:2];
		case (state_q)
			S_CLR: begin
				ck_we = 1'b1;
			end
			S_INIT: begin
				ck_we = 1'b1;
				ck_waddr = '0;
				ck_wdata = {bfha_pkg::CK_FREE, SZ_W'(heap_eff)};
				fl_we = 1'b1;
				fl_waddr = '0;
				fl_wdata = '0;
			end
			S_A_RDC: begin
				ck_raddr = fl_rdata[OFF_W-1:2];
			end
			S_A_DEC: begin
				if (found_q && split) begin
					fl_we = 1'b1;
					fl_waddr = best_i_q[FL_AW-1:0];
					fl_wdata = tail_x[OFF_W-1:0];
				end
			end
			S_R_NRD: begin
				ck_raddr = n_q[OFF_W-1:2];
			end
			S_R_NGET: begin
				ck_raddr = prev_q[OFF_W-1:2];
			end
			S_R_DEC: begin
				if (mrg_next && !mrg_prev) begin
					fl_we = 1'b1;
				end
			end
			S_CW: begin
				ck_we = 1'b1;
				ck_waddr = wq_addr_q[wq_k_q];
				ck_wdata = wq_data_q[wq_k_q];
			end
			S_SD_RD: begin
				fl_raddr = FL_AW'(a_q + CNT_W'(1));
			end
			S_SD_WR: begin
				fl_we = 1'b1;
				fl_waddr = a_q[FL_AW-1:0];
				fl_wdata = fl_rdata;
			end
			S_SU_RD: begin
				fl_raddr = FL_AW'(a_q - CNT_W'(1));
				if (a_q == i_q) begin
					fl_we = 1'b1;
				end
			end
			S_SU_WR: begin
				fl_we = 1'b1;
				fl_waddr = a_q[FL_AW-1:0];
				fl_wdata = fl_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_idx_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.wr) begin
				// re-form the heap: sweep the chunk table from the bottom
				state_q <= S_CLR;
				clr_idx_q <= '0;
			end else begin
				case (state_q)
					S_CLR: begin
						clr_idx_q <= clr_idx_q + CI_W'(1);
						if (clr_idx_q == CI_W'(CHUNK_SLOTS - 1)) begin
							state_q <= S_INIT;
						end
					end
					S_INIT: begin
						count_q <= CNT_W'(1);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (accept) begin
							res_grant_q <= '0;
							i_q <= '0;
							found_q <= 1'b0;
							need_q <= (NEED_W'(in_req) + NEED_W'(3)) & ~NEED_W'(3);
							p_q <= p_x[OFF_W-1:0];
							if (!in_op) begin
								res_status_q <= bfha_pkg::RES_OK;
								state_q <= S_A_RDL;
							end else if (rel_bad) begin
								res_status_q <= bfha_pkg::RES_BADREL;
								state_q <= S_FIN;
							end else begin
								res_status_q <= bfha_pkg::RES_OK;
								state_q <= S_R_CHK;
							end
						end
					end
					S_A_RDL: begin
						state_q <= (i_q == count_q) ? S_A_DEC : S_A_RDC;
					end
					S_A_RDC: begin
						hdr_q <= fl_rdata;
						state_q <= S_A_CMP;
					end
					S_A_CMP: begin
						if (fits && better) begin
							found_q <= 1'b1;
							best_i_q <= i_q;
							best_hdr_q <= hdr_q;
							best_size_q <= ck_rdata[SZ_W-1:0];
						end
						i_q <= i_q + CNT_W'(1);
						state_q <= S_A_RDL;
					end
					S_A_DEC: begin
						wq_k_q <= '0;
						if (!found_q) begin
							res_status_q <= bfha_pkg::RES_NOFIT;
							state_q <= S_FIN;
						end else begin
							res_grant_q <= 16'(AW'(best_hdr_q) + HDR_X);
							state_q <= S_CW;
							if (!split) begin
								// take the whole chunk, drop it from the list
								wq_addr_q[0] <= best_hdr_q[OFF_W-1:2];
								wq_data_q[0] <= {bfha_pkg::CK_ALLOC, best_size_q};
								wq_n_q <= 2'd1;
								post_q <= POST_DOWN;
								a_q <= best_i_q;
							end else begin
								wq_addr_q[0] <= tail_x[OFF_W-1:2];
								wq_data_q[0] <= {bfha_pkg::CK_FREE,
									SZ_W'(AW'(best_size_q) - need8_x)};
								wq_addr_q[1] <= best_hdr_q[OFF_W-1:2];
								wq_data_q[1] <= {bfha_pkg::CK_ALLOC, SZ_W'(need8_x)};
								wq_n_q <= 2'd2;
								post_q <= POST_NONE;
							end
						end
					end
					S_R_CHK: begin
						psize_q <= ck_rdata[SZ_W-1:0];
						if (ck_rdata[CW_W-1:SZ_W] != bfha_pkg::CK_ALLOC) begin
							res_status_q <= bfha_pkg::RES_BADREL;
							state_q <= S_FIN;
						end else begin
							state_q <= S_R_RDL;
						end
					end
					S_R_RDL: begin
						state_q <= (i_q == count_q) ? S_R_NRD : S_R_LCMP;
					end
					S_R_LCMP: begin
						if (fl_rdata >= p_q) begin
							n_q <= fl_rdata;
							state_q <= S_R_NRD;
						end else begin
							prev_q <= fl_rdata;
							i_q <= i_q + CNT_W'(1);
							state_q <= S_R_RDL;
						end
					end
					S_R_NRD: begin
						state_q <= S_R_NGET;
					end
					S_R_NGET: begin
						nsize_q <= ck_rdata[SZ_W-1:0];
						state_q <= S_R_PGET;
					end
					S_R_PGET: begin
						prevsize_q <= ck_rdata[SZ_W-1:0];
						state_q <= S_R_DEC;
					end
					S_R_DEC: begin
						wq_k_q <= '0;
						// a full list with nothing to merge rejects the release
						state_q <= (!mrg_next && !mrg_prev && list_full) ? S_FIN : S_CW;
						if (!mrg_next && !mrg_prev) begin
							if (list_full) begin
								res_status_q <= bfha_pkg::RES_BADREL;
							end else begin
								wq_addr_q[0] <= p_q[OFF_W-1:2];
								wq_data_q[0] <= {bfha_pkg::CK_FREE, psize_q};
								wq_n_q <= 2'd1;
								post_q <= POST_UP;
								a_q <= count_q;
							end
						end else if (!mrg_prev) begin
							// absorb the next chunk; p takes its list slot
							wq_addr_q[0] <= p_q[OFF_W-1:2];
							wq_data_q[0] <= {bfha_pkg::CK_FREE, SZ_W'(psize_q + nsize_q)};
							wq_addr_q[1] <= n_q[OFF_W-1:2];
							wq_data_q[1] <= {bfha_pkg::CK_NONE, SZ_W'(0)};
							wq_n_q <= 2'd2;
							post_q <= POST_NONE;
						end else if (!mrg_next) begin
							wq_addr_q[0] <= prev_q[OFF_W-1:2];
							wq_data_q[0] <= {bfha_pkg::CK_FREE, SZ_W'(prevsize_q + psize_q)};
							wq_addr_q[1] <= p_q[OFF_W-1:2];
							wq_data_q[1] <= {bfha_pkg::CK_NONE, SZ_W'(0)};
							wq_n_q <= 2'd2;
							post_q <= POST_NONE;
						end else begin
							// both sides merge into prev; drop next from the list
							wq_addr_q[0] <= prev_q[OFF_W-1:2];
							wq_data_q[0] <= {bfha_pkg::CK_FREE,
								SZ_W'(prevsize_q + psize_q + nsize_q)};
							wq_addr_q[1] <= p_q[OFF_W-1:2];
							wq_data_q[1] <= {bfha_pkg::CK_NONE, SZ_W'(0)};
							wq_addr_q[2] <= n_q[OFF_W-1:2];
							wq_data_q[2] <= {bfha_pkg::CK_NONE, SZ_W'(0)};
							wq_n_q <= 2'd3;
							post_q <= POST_DOWN;
							a_q <= i_q;
						end
					end
					S_CW: begin
						wq_k_q <= wq_k_q + 2'd1;
						if (wq_k_q == wq_n_q - 2'd1) begin
							case (post_q)
								POST_DOWN: state_q <= S_SD_RD;
								POST_UP:   state_q <= S_SU_RD;
								default:   state_q <= S_FIN;
							endcase
						end
					end
					S_SD_RD: begin
						if (a_q + CNT_W'(1) >= count_q) begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_FIN;
						end else begin
							state_q <= S_SD_WR;
						end
					end
					S_SD_WR: begin
						a_q <= a_q + CNT_W'(1);
						state_q <= S_SD_RD;
					end
					S_SU_RD: begin
						if (a_q == i_q) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_FIN;
						end else begin
							state_q <= S_SU_WR;
						end
					end
					S_SU_WR: begin
						a_q <= a_q - CNT_W'(1);
						state_q <= S_SU_RD;
					end
					S_FIN: begin
						if (out_load) begin
							out_valid_q <= 1'b1;
							out_data_q <= {bfha_pkg::FREEC_W'(count_q), res_status_q, res_grant_q};
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_CLR;
						clr_idx_q <= '0;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// list never holds more entries than slots
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(FREE_SLOTS))
		else $error("free list count overflow");

	// an accepted word always starts work
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> (state_q != S_IDLE))
		else $error("accepted word left sequencer idle");

	// a register write always restarts the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n) cfg.wr |=> (state_q == S_CLR))
		else $error("heap re-form not started");

	// a failed request never grants an offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status_q != bfha_pkg::RES_OK) |-> (res_grant_q == 16'd0))
		else $error("granted offset on failure");

endmodule
